### rtl/core/ieel_pkg.sv
// Package for the indexed insert/erase list.
// Holds sizes, mode and status codes, and the word and command types.
// No dependencies.
package ieel_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int MODE_W    = 3;
    localparam int POS_W     = 5;
    localparam int POS2_W    = 4;
    localparam int ST_W      = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // request modes
    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SWAP    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd6;

    // result status
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // register index of capacity
    localparam logic [PADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;
    localparam logic [CAP_W-1:0]   CAPACITY_RESET    = 5'd16;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [POS_W-1:0]     position;
        logic [POS2_W-1:0]    other_position;
        logic [WORD_BITS-1:0] item_value;
    } in_word_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_value;
        logic [ST_W-1:0]      status;
        logic [CNT_W-1:0]     entry_count;
        logic                 is_empty;
        logic                 is_full;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_req;
        logic commit;
        logic swap_load;
        logic swap_commit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_swap;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/indexed_insert_erase_list.sv
// Channel   | Ports                                 | Word type
// ----------+---------------------------------------+-------------------
// request   | s_valid, s_ready, s_data              | ieel_pkg::in_word_t
// result    | m_valid, m_ready, m_data              | ieel_pkg::out_word_t
// config    | psel, penable, pwrite, paddr, pwdata, | capacity at 0x0
//           | prdata, pready                        |
//
// A request is latched on accept, and its result word is written when the
// execute step commits; a valid swap parks one entry first and commits in swap.
// Insert and erase shift the whole entry row in a single commit.
// Synchronous active-low reset clears the count, the controller and the
// result valid; capacity resets to 16. A stalled result holds the controller
// in execute or swap until the output register frees; no request is taken meanwhile.
module indexed_insert_erase_list (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ieel_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ieel_pkg::out_word_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ieel_pkg::PADDR_W-1:0]    paddr,
    input  logic [ieel_pkg::PDATA_W-1:0]    pwdata,
    output logic [ieel_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    ieel_pkg::ctrl_cmd_t         cmd;
    ieel_pkg::dp_status_t        sts;
    logic [ieel_pkg::CAP_W-1:0]  cap_reg;
    logic                        cap_sel;

    // registers are word aligned; low address bits ignored
    assign cap_sel = (paddr[ieel_pkg::PADDR_W-1:2] ==
                      ieel_pkg::REG_CAPACITY_ADDR[ieel_pkg::PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? ieel_pkg::PDATA_W'(cap_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= ieel_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            cap_reg <= pwdata[ieel_pkg::CAP_W-1:0];
        end
    end

    ieel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ieel_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_data   (s_data),
        .capacity (cap_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### rtl/core/ieel_datapath.sv
// Datapath of the indexed insert/erase list: request register, entry cells,
// count, range checks and the output word register.
// Depends on ieel_pkg.
module ieel_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ieel_pkg::ctrl_cmd_t       cmd,
    output ieel_pkg::dp_status_t      sts,
    input  ieel_pkg::in_word_t        s_data,
    input  logic [ieel_pkg::CAP_W-1:0] capacity,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ieel_pkg::out_word_t       m_data
);

    ieel_pkg::in_word_t                 req_reg;
    logic [ieel_pkg::CNT_W-1:0]         count_reg;
    logic [ieel_pkg::CNT_W-1:0]         count_next;
    logic [ieel_pkg::WORD_BITS-1:0]     entry_reg  [ieel_pkg::DEPTH];
    logic [ieel_pkg::WORD_BITS-1:0]     entry_next [ieel_pkg::DEPTH];
    logic [ieel_pkg::WORD_BITS-1:0]     tmp_reg;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    ieel_pkg::out_word_t                out_reg;
    ieel_pkg::out_word_t                out_next;

    logic [ieel_pkg::CNT_W-1:0]  eff_cap;
    logic                        full;
    logic                        pos_le;
    logic                        pos_lt;
    logic                        pos2_lt;
    logic [ieel_pkg::IDX_W-1:0]  pos_idx;
    logic [ieel_pkg::IDX_W-1:0]  pos2_idx;
    logic [ieel_pkg::ST_W-1:0]   st_c;
    logic [ieel_pkg::WORD_BITS-1:0] rd_c;

    always_comb begin
        if (capacity == '0) begin
            eff_cap = ieel_pkg::CNT_W'(1);
        end else if (capacity > ieel_pkg::CAP_W'(ieel_pkg::DEPTH)) begin
            eff_cap = ieel_pkg::CNT_W'(ieel_pkg::DEPTH);
        end else begin
            eff_cap = ieel_pkg::CNT_W'(capacity);
        end
    end

    assign full     = count_reg >= eff_cap;
    assign pos_le   = ieel_pkg::CNT_W'(req_reg.position) <= count_reg;
    assign pos_lt   = ieel_pkg::CNT_W'(req_reg.position) < count_reg;
    assign pos2_lt  = ieel_pkg::CNT_W'(req_reg.other_position) < count_reg;
    assign pos_idx  = req_reg.position[ieel_pkg::IDX_W-1:0];
    assign pos2_idx = req_reg.other_position[ieel_pkg::IDX_W-1:0];

    assign sts.needs_swap = (req_reg.mode == ieel_pkg::MODE_SWAP) && pos_lt && pos2_lt;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        st_c       = ieel_pkg::ST_DONE;
        rd_c       = '0;
        count_next = count_reg;
        for (int i = 0; i < ieel_pkg::DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
        end
        case (req_reg.mode)
            ieel_pkg::MODE_APPEND: begin
                if (full) begin
                    st_c = ieel_pkg::ST_FULL;
                end else begin
                    // count below capacity, so it fits an index
                    entry_next[count_reg[ieel_pkg::IDX_W-1:0]] = req_reg.item_value;
                    count_next = count_reg + ieel_pkg::CNT_W'(1);
                end
            end
            ieel_pkg::MODE_INSERT: begin
                if (!pos_le) begin
                    st_c = ieel_pkg::ST_RANGE;
                end else if (full) begin
                    st_c = ieel_pkg::ST_FULL;
                end else begin
                    for (int i = 1; i < ieel_pkg::DEPTH; i++) begin
                        if (ieel_pkg::CNT_W'(i) > ieel_pkg::CNT_W'(req_reg.position)) begin
                            entry_next[i] = entry_reg[i-1];
                        end
                    end
                    entry_next[pos_idx] = req_reg.item_value;
                    count_next = count_reg + ieel_pkg::CNT_W'(1);
                end
            end
            ieel_pkg::MODE_ERASE: begin
                if (!pos_lt) begin
                    st_c = ieel_pkg::ST_RANGE;
                end else begin
                    for (int i = 0; i < ieel_pkg::DEPTH - 1; i++) begin
                        if (ieel_pkg::CNT_W'(i) >= ieel_pkg::CNT_W'(req_reg.position)) begin
                            entry_next[i] = entry_reg[i+1];
                        end
                    end
                    count_next = count_reg - ieel_pkg::CNT_W'(1);
                end
            end
            ieel_pkg::MODE_READ: begin
                if (!pos_lt) begin
                    st_c = ieel_pkg::ST_RANGE;
                end else begin
                    rd_c = entry_reg[pos_idx];
                end
            end
            ieel_pkg::MODE_REPLACE: begin
                if (!pos_lt) begin
                    st_c = ieel_pkg::ST_RANGE;
                end else begin
                    entry_next[pos_idx] = req_reg.item_value;
                end
            end
            ieel_pkg::MODE_SWAP: begin
                if (!(pos_lt && pos2_lt)) begin
                    st_c = ieel_pkg::ST_RANGE;
                end
            end
            ieel_pkg::MODE_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
        // second half of a swap; first entry was parked in tmp_reg
        if (cmd.swap_commit) begin
            entry_next[pos_idx]  = entry_reg[pos2_idx];
            entry_next[pos2_idx] = tmp_reg;
        end
    end

    always_comb begin
        out_next.read_value  = rd_c;
        out_next.status      = st_c;
        out_next.entry_count = count_next;
        out_next.is_empty    = (count_next == '0);
        out_next.is_full     = (count_next >= eff_cap);
    end

    always_comb begin
        if (cmd.commit || cmd.swap_commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.commit) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_reg <= s_data;
        end
        if (cmd.swap_load) begin
            tmp_reg <= entry_reg[pos_idx];
        end
        if (cmd.commit || cmd.swap_commit) begin
            out_reg <= out_next;
            for (int i = 0; i < ieel_pkg::DEPTH; i++) begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/core/ieel_ctrl.sv
// Controller of the indexed insert/erase list: sequences accept, execute
// and the two-step swap. Depends on ieel_pkg.
module ieel_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ieel_pkg::dp_status_t  sts,
    output ieel_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SWAP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        cmd.latch_req   = 1'b0;
        cmd.commit      = 1'b0;
        cmd.swap_load   = 1'b0;
        cmd.swap_commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.needs_swap) begin
                    cmd.swap_load = 1'b1;
                    state_next    = S_SWAP;
                end else if (sts.out_free) begin
                    // op and result word land together, only when the
                    // output register can take the word
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SWAP: begin
                if (sts.out_free) begin
                    cmd.swap_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### test/indexed_insert_erase_list_checker.sv
`timescale 1ns / 1ps
// Scoreboard for indexed_insert_erase_list: follows capacity writes on the config port,
// predicts each result word from the accepted requests and compares it field by field.
// Depends on ieel_pkg.
module indexed_insert_erase_list_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ieel_pkg::in_word_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ieel_pkg::out_word_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ieel_pkg::PADDR_W-1:0]    paddr,
    input  logic [ieel_pkg::PDATA_W-1:0]    pwdata,
    input  logic                            pready,
    output int                              mismatch_count,
    output int                              results_checked,
    output int                              results_pending,
    output int                              list_len
);
    import ieel_pkg::*;

    logic [WORD_BITS-1:0] stored [DEPTH];
    logic [CAP_W-1:0]     cap_setting;
    int                   fill;
    out_word_t            expected_q [$];
    out_word_t            want;

    assign list_len = fill;

    // Applies one request to the shadow list and returns the result word it should produce.
    function automatic out_word_t apply_request(in_word_t req);
        out_word_t            res;
        int                   cap_eff;
        int                   pos;
        int                   pos2;
        logic                 at_limit;
        logic [WORD_BITS-1:0] held;
        res = '0;
        cap_eff = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : int'(cap_setting));
        pos = int'(req.position);
        pos2 = int'(req.other_position);
        at_limit = (fill >= cap_eff);
        res.status = ST_DONE;
        case (req.mode)
            MODE_APPEND: begin
                if (at_limit) begin
                    res.status = ST_FULL;
                end else begin
                    stored[fill] = req.item_value;
                    fill++;
                end
            end
            MODE_INSERT: begin
                // index is checked ahead of fullness
                if (pos > fill) begin
                    res.status = ST_RANGE;
                end else if (at_limit) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = fill; k > pos; k--) stored[k] = stored[k-1];
                    stored[pos] = req.item_value;
                    fill++;
                end
            end
            MODE_ERASE: begin
                if (pos >= fill) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int k = pos + 1; k < fill; k++) stored[k-1] = stored[k];
                    fill--;
                end
            end
            MODE_READ: begin
                if (pos >= fill) res.status = ST_RANGE;
                else res.read_value = stored[pos];
            end
            MODE_REPLACE: begin
                if (pos >= fill) res.status = ST_RANGE;
                else stored[pos] = req.item_value;
            end
            MODE_SWAP: begin
                if (pos >= fill || pos2 >= fill) begin
                    res.status = ST_RANGE;
                end else begin
                    held = stored[pos];
                    stored[pos] = stored[pos2];
                    stored[pos2] = held;
                end
            end
            MODE_CLEAR: begin
                fill = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = fill[CNT_W-1:0];
        res.is_empty = (fill == 0);
        res.is_full = (fill >= cap_eff);
        return res;
    endfunction

    task automatic check_field(string field, logic [WORD_BITS-1:0] want_v,
                               logic [WORD_BITS-1:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("%0t: word %0d %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, results_checked, field, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill = 0;
            cap_setting = CAPACITY_RESET;
            expected_q.delete();
            results_pending = 0;
            results_checked = 0;
            mismatch_count = 0;
            for (int k = 0; k < DEPTH; k++) stored[k] = '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_CAPACITY_ADDR)
                cap_setting = pwdata[CAP_W-1:0];
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with nothing outstanding, expected none, got 0x%0h",
                             $time, m_data);
                end else begin
                    want = expected_q.pop_front();
                    check_field("read_value", want.read_value, m_data.read_value);
                    check_field("status", want.status, m_data.status);
                    check_field("entry_count", want.entry_count, m_data.entry_count);
                    check_field("is_empty", want.is_empty, m_data.is_empty);
                    check_field("is_full", want.is_full, m_data.is_full);
                end
                results_checked++;
            end
            if (s_valid && s_ready) expected_q.push_back(apply_request(s_data));
            results_pending = expected_q.size();
        end
    end

endmodule

### test/indexed_insert_erase_list_tb.sv
`timescale 1ns / 1ps
// Top of the indexed_insert_erase_list testbench: clock, reset, request and result traffic,
// capacity writes over the config port, and the verdict. Needs ieel_pkg, the block and the checker.
module indexed_insert_erase_list_tb;
    import ieel_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_word_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_word_t           m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int mismatch_count;
    int results_checked;
    int results_pending;
    int list_len;
    int requests_sent = 0;
    bit calm = 1'b0;
    bit stall_burst = 1'b0;
    int cap_plan [10] = '{31, 4, 16, 0, 17, 9, 1, 16, 2, 12};

    always #2 aclk = ~aclk;

    indexed_insert_erase_list u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    indexed_insert_erase_list_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .results_pending (results_pending),
        .list_len        (list_len)
    );

    function automatic in_word_t make_req(logic [MODE_W-1:0] mode, int pos, int pos2,
                                          logic [WORD_BITS-1:0] value);
        in_word_t req;
        req.mode = mode;
        req.position = POS_W'(pos);
        req.other_position = POS2_W'(pos2);
        req.item_value = value;
        return req;
    endfunction

    // Mostly in-range indexes against the current list length, plus some fully random words.
    function automatic in_word_t random_request();
        in_word_t    req;
        logic [63:0] raw;
        int          pick;
        int          last;
        raw = {$urandom, $urandom};
        req = raw[$bits(in_word_t)-1:0];
        if ($urandom_range(0, 99) < 12) return req;
        last = (list_len == 0) ? 0 : list_len - 1;
        pick = $urandom_range(0, 199);
        if (pick < 56) begin
            req.mode = MODE_APPEND;
        end else if (pick < 96) begin
            req.mode = MODE_INSERT;
            req.position = POS_W'($urandom_range(0, list_len));
        end else if (pick < 126) begin
            req.mode = MODE_ERASE;
            req.position = POS_W'($urandom_range(0, last));
        end else if (pick < 154) begin
            req.mode = MODE_READ;
            req.position = POS_W'($urandom_range(0, last));
        end else if (pick < 172) begin
            req.mode = MODE_REPLACE;
            req.position = POS_W'($urandom_range(0, last));
        end else if (pick < 193) begin
            req.mode = MODE_SWAP;
            req.position = POS_W'($urandom_range(0, last));
            req.other_position = POS2_W'($urandom_range(0, last));
        end else if (pick < 196) begin
            req.mode = MODE_CLEAR;
        end else begin
            req.mode = MODE_SPARE;
        end
        return req;
    endfunction

    task automatic send_request(in_word_t req);
        if (!calm && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests_sent++;
    endtask

    // Only written with the block drained.
    task automatic write_capacity(logic [PDATA_W-1:0] value);
        s_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (4) @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_CAPACITY_ADDR;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // result side: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_burst) begin
                m_ready <= 1'b0;
                repeat (80) @(negedge aclk);
                stall_burst = 1'b0;
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    initial begin
        int eff;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list, reset capacity
        send_request(make_req(MODE_READ, 0, 0, 32'h0));
        send_request(make_req(MODE_ERASE, 0, 0, 32'h0));
        send_request(make_req(MODE_INSERT, 1, 0, 32'h1234_5678));
        send_request(make_req(MODE_SWAP, 0, 0, 32'h0));
        send_request(make_req(MODE_SPARE, 0, 0, 32'hFFFF_FFFF));
        send_request(make_req(MODE_CLEAR, 0, 0, 32'h0));
        send_request(make_req(MODE_INSERT, 0, 0, 32'hFFFF_FFFF));
        send_request(make_req(MODE_APPEND, 0, 0, 32'h0000_0000));
        send_request(make_req(MODE_INSERT, 1, 0, 32'h8000_0001));
        send_request(make_req(MODE_INSERT, 3, 0, 32'h7FFF_FFFE));
        send_request(make_req(MODE_READ, 1, 0, 32'h0));
        send_request(make_req(MODE_REPLACE, 2, 0, 32'h5555_AAAA));
        send_request(make_req(MODE_SWAP, 0, 3, 32'h0));
        send_request(make_req(MODE_SWAP, 2, 2, 32'h0));
        send_request(make_req(MODE_SWAP, 0, 4, 32'h0));
        send_request(make_req(MODE_READ, 16, 15, 32'h0));
        send_request(make_req(MODE_ERASE, 31, 0, 32'h0));
        send_request(make_req(MODE_REPLACE, 4, 0, 32'hDEAD_BEEF));
        send_request(make_req(MODE_ERASE, 0, 0, 32'h0));
        send_request(make_req(MODE_ERASE, 2, 0, 32'h0));

        // capacity dropped below the current count
        write_capacity(1);
        send_request(make_req(MODE_APPEND, 0, 0, 32'hA5A5_A5A5));
        send_request(make_req(MODE_INSERT, 0, 0, 32'h5A5A_5A5A));
        send_request(make_req(MODE_INSERT, 5, 0, 32'h0F0F_0F0F));
        send_request(make_req(MODE_READ, 1, 0, 32'h0));
        send_request(make_req(MODE_CLEAR, 0, 0, 32'h0));

        foreach (cap_plan[p]) begin
            write_capacity(cap_plan[p]);
            eff = (cap_plan[p] == 0) ? 1 : ((cap_plan[p] > DEPTH) ? DEPTH : cap_plan[p]);
            calm = (p == 3);
            // fill to the limit, then one append that must be refused
            while (list_len < eff) send_request(make_req(MODE_APPEND, 0, 0, $urandom));
            send_request(make_req(MODE_APPEND, 0, 0, $urandom));
            for (int n = 0; n < 45; n++) begin
                if (p == 1 && n == 10) stall_burst = 1'b1;
                send_request(random_request());
            end
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (8) @(posedge aclk);
        $display("summary: %0d requests, %0d result words compared, capacity swept 0..31",
                 requests_sent, results_checked);
        $display("summary: all seven modes plus the spare code, refusals for range and fullness");
        if (mismatch_count == 0) begin
            $display("indexed_insert_erase_list_tb: done, clean");
        end else begin
            $display("indexed_insert_erase_list_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d result words outstanding", results_pending);
        $display("indexed_insert_erase_list_tb: done, errors");
        $finish;
    end

endmodule
